// ===== src/mstt_pkg.sv =====
// shared types and constants for the timeout table
package mstt_pkg;

  localparam int unsigned CNT_W       = 32;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_W       = 3;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ADD  = 1'b1;

  localparam logic REPLY_ADD    = 1'b0;
  localparam logic REPLY_EXPIRY = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] dec;
    logic             was_zero;
    logic             now_zero;
  } dec_res_t;

  typedef struct packed {
    logic              reply_kind;
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  event_tag;
    logic [CNT_W-1:0]  ms_count;
    logic              last;
  } result_t;

endpackage

// ===== src/multi_slot_timeout_table_core.sv =====
// top level of the multi-slot one-shot timeout table
//
// input channel (in_valid/in_ready) carries one request: kind 0 is a
// millisecond tick, kind 1 adds a timeout of in_duration ticks with a tag
// and a notify flag. the result channel (out_valid/out_ready) returns one
// add reply per add, and for a tick one expiry event per notifying slot
// that reaches zero, lowest slot first, at most four, the final one with
// out_last set. a quiet tick returns nothing.
// a sequencer walks the slots one per cycle while the scan is not paused,
// through a single shared decrement/compare unit, so a request occupies the
// block for its scan (an add stops at the lowest free slot) and flush plus
// any receiver stall; in_ready is low meanwhile. one result register and one
// hold register sit between the scan and the port, so the scan only pauses
// when both are full and out_ready is low.
// reset (rst_n low, synchronous) clears the millisecond counter and frees
// every slot; tags and notify flags stay unset until written.
module multi_slot_timeout_table_core
  import mstt_pkg::*;
#(
  parameter int unsigned SLOTS = 4
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [CNT_W-1:0]  in_duration,
  input  logic [TAG_W-1:0]  in_tag,
  input  logic              in_notify,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_reply_kind,
  output logic              out_accepted,
  output logic [SLOT_W-1:0] out_slot,
  output logic [TAG_W-1:0]  out_event_tag,
  output logic [CNT_W-1:0]  out_ms_count,
  output logic              out_last
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;

  logic [2:0]       state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [RES_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] dur_r;
  logic [TAG_W-1:0] tag_in_r;
  logic             notify_in_r;

  logic [CNT_W-1:0] remaining_r [SLOTS];
  logic [TAG_W-1:0] slot_tag_r [SLOTS];
  logic             slot_notify_r [SLOTS];

  result_t hold_r, hold_nxt;
  logic    hold_valid_r, hold_valid_nxt;
  result_t out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;

  logic             out_free;
  logic             step_go;
  logic             in_fire;
  logic             rem_we;
  logic [CNT_W-1:0] rem_wdata;
  logic             meta_we;
  logic [CNT_W-1:0] cur_val;
  logic [IW+1:0]    idx_ext;
  logic [SLOT_W-1:0] idx_slot;
  dec_res_t         dres;
  result_t          new_res;

  assign cur_val  = remaining_r[idx_r];
  assign idx_ext  = {2'b00, idx_r};
  assign idx_slot = idx_ext[SLOT_W-1:0];

  mstt_dec_unit u_dec (
    .value (cur_val),
    .res   (dres)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign step_go  = !(hold_valid_r && !out_free);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    tick_nxt       = tick_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    rem_we         = 1'b0;
    rem_wdata      = dres.dec;
    meta_we        = 1'b0;
    new_res        = '0;
    new_res.ms_count = tick_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          if (in_kind == KIND_ADD) begin
            state_nxt = ST_ADD;
          end else begin
            tick_nxt  = tick_r + CNT_W'(1);
            state_nxt = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        if (step_go) begin
          if (!dres.was_zero) begin
            rem_we = 1'b1;
            if (dres.now_zero && slot_notify_r[idx_r] &&
                (cnt_r < RES_W'(MAX_RESULTS))) begin
              new_res.reply_kind = REPLY_EXPIRY;
              new_res.slot       = idx_slot;
              new_res.event_tag  = slot_tag_r[idx_r];
              cnt_nxt            = cnt_r + RES_W'(1);
              if (hold_valid_r) begin
                out_nxt       = hold_r;
                out_valid_nxt = 1'b1;
              end
              hold_nxt       = new_res;
              hold_valid_nxt = 1'b1;
            end
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      ST_ADD: begin
        new_res.reply_kind = REPLY_ADD;
        if (dres.was_zero) begin
          rem_we           = 1'b1;
          rem_wdata        = dur_r;
          meta_we          = 1'b1;
          new_res.accepted = 1'b1;
          new_res.slot     = idx_slot;
          hold_nxt         = new_res;
          hold_valid_nxt   = 1'b1;
          state_nxt        = ST_FLUSH;
        end else if (idx_r == LAST_IDX) begin
          hold_nxt       = new_res;
          hold_valid_nxt = 1'b1;
          state_nxt      = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt        = hold_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      cnt_r        <= '0;
      tick_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      tick_r       <= tick_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        remaining_r[i] <= '0;
      end
    end else if (rem_we) begin
      remaining_r[idx_r] <= rem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    if (in_fire) begin
      dur_r       <= in_duration;
      tag_in_r    <= in_tag;
      notify_in_r <= in_notify;
    end
    if (meta_we) begin
      slot_tag_r[idx_r]    <= tag_in_r;
      slot_notify_r[idx_r] <= notify_in_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = out_r.reply_kind;
  assign out_accepted   = out_r.accepted;
  assign out_slot       = out_r.slot;
  assign out_event_tag  = out_r.event_tag;
  assign out_ms_count   = out_r.ms_count;
  assign out_last       = out_r.last;

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_valid_r)
    else $error("pending result left behind when the sequencer went idle");

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_W'(MAX_RESULTS))
    else $error("expiry result count exceeds the per-tick limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("sequencer did not start after a request was taken");

  a_add_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> (!hold_valid_r && (cnt_r == '0)))
    else $error("add scan started with a result still pending");

endmodule

// ===== src/mstt_dec_unit.sv =====
// shared decrement and zero-compare unit for slot counts
module mstt_dec_unit
  import mstt_pkg::*;
(
  input  logic [CNT_W-1:0] value,
  output dec_res_t         res
);

  always_comb begin
    res.dec      = value - CNT_W'(1);
    res.was_zero = (value == '0);
    res.now_zero = (value == CNT_W'(1));
  end

endmodule
